// File: hdl/tdls_pkg.sv
// tdls_pkg: shared types, constants and glyph table for the two-digit led frame sequencer
// depends on nothing; imported by every module of the block
`default_nettype none

package tdls_pkg;

    localparam int ByteW = 8;
    localparam int ValueW = 7;
    localparam int PatW = 7;
    localparam int StepW = 5;
    localparam int CfgIndexW = 2;

    localparam logic [ByteW-1:0] CmdWrite = 8'h40;
    localparam logic [ByteW-1:0] AddrBase = 8'hC0;
    localparam logic [ByteW-1:0] ModeReset = 8'h03;
    localparam logic [ByteW-1:0] ControlReset = 8'h8F;

    localparam logic [3:0] GlyphE = 4'd10;
    localparam logic [ValueW-1:0] NumberMax = 7'd99;
    localparam logic [ValueW-1:0] CodeMax = 7'd10;
    localparam logic [ValueW-1:0] TwoDigitMin = 7'd10;

    // request kinds
    localparam logic OpNumber = 1'b0;
    localparam logic OpError = 1'b1;

    // register indexes
    localparam logic [CfgIndexW-1:0] RegMode = 2'd0;
    localparam logic [CfgIndexW-1:0] RegControl = 2'd1;

    // byte positions within one request
    localparam logic [StepW-1:0] StepMode = 5'd0;
    localparam logic [StepW-1:0] StepControl = 5'd1;
    localparam logic [StepW-1:0] StepWrite = 5'd2;
    localparam logic [StepW-1:0] StepRowFirst = 5'd3;
    localparam logic [StepW-1:0] StepLast = 5'd16;
    localparam logic [2:0] RowLast = 3'd6;

    // classified request handed from front to back
    typedef struct packed {
        logic err;
        logic setup;
        logic [PatW-1:0] hi_pat;
        logic [PatW-1:0] lo_pat;
    } desc_t;

    function automatic logic [PatW-1:0] glyph(input logic [3:0] digit);
        logic [PatW-1:0] pat;
        unique case (digit)
            4'd0: pat = 7'h3F;
            4'd1: pat = 7'h06;
            4'd2: pat = 7'h5B;
            4'd3: pat = 7'h4F;
            4'd4: pat = 7'h66;
            4'd5: pat = 7'h6D;
            4'd6: pat = 7'h7D;
            4'd7: pat = 7'h07;
            4'd8: pat = 7'h7F;
            4'd9: pat = 7'h6F;
            default: pat = 7'h79;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tdls_front.sv
// tdls_front: accepts requests, clamps them and turns them into segment patterns
// depends on tdls_pkg
`default_nettype none

module tdls_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic                        op,
    input  wire logic [tdls_pkg::ValueW-1:0] value,
    input  wire logic                        queue_full,
    output tdls_pkg::desc_t                  desc,
    output logic                             desc_push
);
    import tdls_pkg::*;

    logic              setup_done_reg;
    logic [ValueW-1:0] num_clamped;
    logic [ValueW-1:0] code_clamped;
    logic [14:0]       tens_prod;
    logic [3:0]        tens;
    logic [3:0]        units;

    assign desc_push = push && !queue_full;

    always_comb
    begin
        num_clamped = (value > NumberMax) ? NumberMax : value;
        code_clamped = (value > CodeMax) ? CodeMax : value;
        // divide by ten as multiply by 205 and shift, exact up to 99
        tens_prod = 15'(num_clamped) * 15'd205;
        tens = tens_prod[14:11];
        units = 4'(num_clamped - 7'(tens) * 7'd10);

        desc.err = op;
        desc.setup = !setup_done_reg;
        if (op == OpError)
        begin
            desc.hi_pat = glyph(code_clamped[3:0]);
            desc.lo_pat = glyph(GlyphE);
        end
        else if (num_clamped < TwoDigitMin)
        begin
            desc.hi_pat = glyph(num_clamped[3:0]);
            desc.lo_pat = '0;
        end
        else
        begin
            desc.hi_pat = glyph(units);
            desc.lo_pat = glyph(tens);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_done_reg <= 1'b0;
        else if (desc_push)
            setup_done_reg <= 1'b1;
    end

endmodule

`default_nettype wire

// File: hdl/tdls_queue.sv
// tdls_queue: two-entry queue of classified requests between front and back
// depends on tdls_pkg
`default_nettype none

module tdls_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  tdls_pkg::desc_t wr_desc,
    input  wire logic  rd_en,
    output tdls_pkg::desc_t rd_desc,
    output logic       full,
    output logic       not_empty
);
    import tdls_pkg::*;

    desc_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_desc = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tdls_back.sv
// tdls_back: byte sequencer and output register, holds the command registers
// depends on tdls_pkg
`default_nettype none

module tdls_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [tdls_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [tdls_pkg::ByteW-1:0]     cfg_data,
    input  tdls_pkg::desc_t                     head_desc,
    input  wire logic                           head_valid,
    output logic                                head_take,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [tdls_pkg::ByteW-1:0]          wire_byte,
    output logic                                strobe_open,
    output logic                                strobe_close,
    output logic                                last
);
    import tdls_pkg::*;

    logic [ByteW-1:0] mode_reg;
    logic [ByteW-1:0] control_reg;
    desc_t            cur_reg;
    logic             busy_reg;
    logic [StepW-1:0] step_reg;
    logic             out_valid_reg;
    logic [ByteW-1:0] byte_reg;
    logic             open_reg;
    logic             close_reg;
    logic             last_reg;

    logic             advance;
    logic             at_last;
    logic [3:0]       row_step;
    logic [2:0]       row;
    logic [ByteW-1:0] byte_next;
    logic             open_next;
    logic             close_next;

    assign empty = !out_valid_reg;
    assign wire_byte = byte_reg;
    assign strobe_open = open_reg;
    assign strobe_close = close_reg;
    assign last = last_reg;

    assign advance = busy_reg && (!out_valid_reg || pop);
    assign at_last = (step_reg == StepLast);
    assign head_take = head_valid && (!busy_reg || (advance && at_last));

    always_comb
    begin
        row_step = 4'(step_reg - StepRowFirst);
        row = row_step[3:1];
        byte_next = CmdWrite;
        open_next = 1'b1;
        close_next = 1'b1;
        if (step_reg == StepMode)
            byte_next = mode_reg;
        else if (step_reg == StepControl)
            byte_next = control_reg;
        else if (step_reg == StepWrite)
            byte_next = CmdWrite;
        else if (!row_step[0])
        begin
            // address byte of a row
            byte_next = AddrBase + {4'd0, row, 1'b0};
            open_next = !cur_reg.err || (row == 3'd0);
            close_next = 1'b0;
        end
        else
        begin
            byte_next = {6'd0, cur_reg.hi_pat[row], cur_reg.lo_pat[row]};
            open_next = 1'b0;
            close_next = !cur_reg.err || (row == RowLast);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ModeReset;
            control_reg <= ControlReset;
        end
        else if (cfg_write)
        begin
            if (cfg_index == RegMode)
                mode_reg <= cfg_data;
            else if (cfg_index == RegControl)
                control_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= StepWrite;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_take)
            begin
                busy_reg <= 1'b1;
                step_reg <= head_desc.setup ? StepMode : StepWrite;
            end
            else if (advance && at_last)
                busy_reg <= 1'b0;
            else if (advance)
                step_reg <= step_reg + 5'd1;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
            cur_reg <= head_desc;
        if (advance)
        begin
            byte_reg <= byte_next;
            open_reg <= open_next;
            close_reg <= close_next;
            last_reg <= at_last;
        end
    end

endmodule

`default_nettype wire

// File: hdl/two_digit_led_frame_sequencer_top.sv
// two_digit_led_frame_sequencer_top: front classifier, request queue and byte sequencer
// depends on tdls_pkg, tdls_front, tdls_queue, tdls_back
// each request gives 15 bytes, 17 for the first after reset, one byte per cycle while pop keeps up
// the byte sequencer takes the next queued request as it sends the last byte of the current one
// a request accepted when idle passes the queue slot, the sequencer step register and the output byte register
// reset empties the queue and the output register and clears the setup flag; registers return to 0x03, 0x8f
`default_nettype none

module two_digit_led_frame_sequencer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [tdls_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [tdls_pkg::ByteW-1:0]     cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           op,
    input  wire logic [tdls_pkg::ValueW-1:0]    value,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [tdls_pkg::ByteW-1:0]          wire_byte,
    output logic                                strobe_open,
    output logic                                strobe_close,
    output logic                                last
);
    import tdls_pkg::*;

    desc_t front_desc;
    desc_t head_desc;
    logic  front_push;
    logic  head_valid;
    logic  head_take;

    tdls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .op         (op),
        .value      (value),
        .queue_full (full),
        .desc       (front_desc),
        .desc_push  (front_push)
    );

    tdls_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_push),
        .wr_desc   (front_desc),
        .rd_en     (head_take),
        .rd_desc   (head_desc),
        .full      (full),
        .not_empty (head_valid)
    );

    tdls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_desc    (head_desc),
        .head_valid   (head_valid),
        .head_take    (head_take),
        .pop          (pop),
        .empty        (empty),
        .wire_byte    (wire_byte),
        .strobe_open  (strobe_open),
        .strobe_close (strobe_close),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_two_digit_led_frame_sequencer_top.sv
// tb_two_digit_led_frame_sequencer_top: self-checking bench for the led frame sequencer
// drives requests and register writes, predicts every wire byte and its strobe flags
// depends on tdls_pkg and two_digit_led_frame_sequencer_top
`timescale 1ns / 1ps

module tb_two_digit_led_frame_sequencer_top;

    import tdls_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 20;
    localparam int HoldOffCycles = 400;

    // indexes with no register behind them
    localparam logic [CfgIndexW-1:0] RegSpareA = 2'd2;
    localparam logic [CfgIndexW-1:0] RegSpareB = 2'd3;

    typedef struct packed {
        logic [ByteW-1:0] wbyte;
        logic             s_open;
        logic             s_close;
        logic             fin;
    } led_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CfgIndexW-1:0] cfg_index;
    logic [ByteW-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic                 op;
    logic [ValueW-1:0]    value;
    logic                 empty;
    logic                 pop;
    logic [ByteW-1:0]     wire_byte;
    logic                 strobe_open;
    logic                 strobe_close;
    logic                 last;

    // predictor state
    logic [ByteW-1:0] mode_shadow;
    logic [ByteW-1:0] control_shadow;
    logic             setup_sent;
    led_byte_t        wire_bytes_due[$];

    int error_count;
    int cycle_count;
    int gap_max;
    int stall_max;
    int hold_off_req;

    two_digit_led_frame_sequencer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .op           (op),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .wire_byte    (wire_byte),
        .strobe_open  (strobe_open),
        .strobe_close (strobe_close),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, wire_bytes_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // segment a..g in bits 0..6, index 10 is the letter E
    function automatic logic [PatW-1:0] segment_font(input logic [3:0] digit);
        logic [PatW-1:0] pat;
        case (digit)
            4'd0: pat = 7'b0111111;
            4'd1: pat = 7'b0000110;
            4'd2: pat = 7'b1011011;
            4'd3: pat = 7'b1001111;
            4'd4: pat = 7'b1100110;
            4'd5: pat = 7'b1101101;
            4'd6: pat = 7'b1111101;
            4'd7: pat = 7'b0000111;
            4'd8: pat = 7'b1111111;
            4'd9: pat = 7'b1101111;
            default: pat = 7'b1111001;
        endcase
        return pat;
    endfunction

    task automatic push_due(input logic [ByteW-1:0] b, input logic o, input logic c,
                            input logic f);
        led_byte_t e;
        e.wbyte = b;
        e.s_open = o;
        e.s_close = c;
        e.fin = f;
        wire_bytes_due.push_back(e);
    endtask

    task automatic predict_led_frames(input logic req_op, input logic [ValueW-1:0] req_val);
        logic [ValueW-1:0] shown;
        logic [PatW-1:0]   units_pat;
        logic [PatW-1:0]   tens_pat;
        logic [ByteW-1:0]  addr;
        logic [ByteW-1:0]  data;
        int                row;
        if (!setup_sent)
        begin
            push_due(mode_shadow, 1'b1, 1'b1, 1'b0);
            push_due(control_shadow, 1'b1, 1'b1, 1'b0);
            setup_sent = 1'b1;
        end
        push_due(CmdWrite, 1'b1, 1'b1, 1'b0);
        if (req_op == OpNumber)
        begin
            shown = (req_val > NumberMax) ? NumberMax : req_val;
            if (shown < TwoDigitMin)
            begin
                units_pat = segment_font(shown[3:0]);
                tens_pat = '0;
            end
            else
            begin
                units_pat = segment_font(4'(shown % 10));
                tens_pat = segment_font(4'(shown / 10));
            end
        end
        else
        begin
            shown = (req_val > CodeMax) ? CodeMax : req_val;
            units_pat = segment_font(shown[3:0]);
            tens_pat = segment_font(GlyphE);
        end
        for (row = 0; row < 7; row++)
        begin
            addr = AddrBase + 8'(2 * row);
            data = {6'b0, units_pat[row], tens_pat[row]};
            if (req_op == OpNumber)
            begin
                push_due(addr, 1'b1, 1'b0, 1'b0);
                push_due(data, 1'b0, 1'b1, row == 6);
            end
            else
            begin
                // error display opens the strobe only on the first of the fourteen bytes and closes it only on the last
                push_due(addr, row == 0, 1'b0, 1'b0);
                push_due(data, 1'b0, row == 6, row == 6);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0h, expected %0h (cycle %0d)",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic check_led_byte();
        led_byte_t want;
        if (wire_bytes_due.size() == 0)
        begin
            report_mismatch("unexpected byte", wire_byte, 0);
        end
        else
        begin
            want = wire_bytes_due.pop_front();
            if (wire_byte !== want.wbyte)
                report_mismatch("wire_byte", wire_byte, want.wbyte);
            if (strobe_open !== want.s_open)
                report_mismatch("strobe_open", strobe_open, want.s_open);
            if (strobe_close !== want.s_close)
                report_mismatch("strobe_close", strobe_close, want.s_close);
            if (last !== want.fin)
                report_mismatch("last", last, want.fin);
        end
    endtask

    // receiver: random stall per item, plus a long hold-off on request
    initial
    begin : byte_receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_led_byte();
                stall_left = $urandom_range(0, stall_max);
            end
            if (hold_off_req > 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic req_op, input logic [ValueW-1:0] req_val);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        op <= req_op;
        value <= req_val;
        do
            @(posedge clk);
        while (full);
        predict_led_frames(req_op, req_val);
    endtask

    task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [ByteW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        // registers only matter until the setup frames have gone out
        if (!setup_sent)
        begin
            if (idx == RegMode)
                mode_shadow = data;
            else if (idx == RegControl)
                control_shadow = data;
        end
        @(posedge clk);
    endtask

    task automatic wait_all_bytes_seen();
        push <= 1'b0;
        while (wire_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ValueW-1:0] pick_value(input logic req_op);
        logic [ValueW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = (req_op == OpNumber) ? 7'($urandom_range(0, 9)) : 7'($urandom_range(0, 10));
            1: v = (req_op == OpNumber) ? 7'($urandom_range(10, 99)) : 7'($urandom_range(0, 10));
            2: v = 7'($urandom_range(0, 127));
            default: v = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(100, 127))
                                                       : 7'($urandom_range(11, 127));
        endcase
        return v;
    endfunction

    task automatic test_register_setup();
        write_register(RegMode, 8'h00);
        write_register(RegControl, 8'hFF);
        write_register(RegMode, 8'hFF);
        write_register(RegControl, 8'h00);
        write_register(RegSpareA, 8'hA5);
        write_register(RegSpareB, 8'h5A);
    endtask

    task automatic test_number_extremes();
        send_request(OpNumber, 7'd0);
        send_request(OpNumber, 7'd5);
        send_request(OpNumber, 7'd9);
        send_request(OpNumber, 7'd10);
        send_request(OpNumber, 7'd42);
        send_request(OpNumber, 7'd99);
        send_request(OpNumber, 7'd100);
        send_request(OpNumber, 7'd127);
    endtask

    task automatic test_error_codes();
        send_request(OpError, 7'd0);
        send_request(OpError, 7'd7);
        send_request(OpError, 7'd10);
        send_request(OpError, 7'd11);
        send_request(OpError, 7'd127);
        send_request(OpError, 7'd88);
    endtask

    task automatic test_late_register_write();
        wait_all_bytes_seen();
        write_register(RegMode, 8'($urandom_range(0, 255)));
        write_register(RegControl, 8'($urandom_range(0, 255)));
        write_register(RegSpareB, 8'hFF);
        send_request(OpNumber, 7'd1);
        send_request(OpError, 7'd3);
    endtask

    // receiver holds off while items keep coming, so the queue fills and full rises
    task automatic test_full_queue_stall();
        logic req_op;
        int   i;
        wait_all_bytes_seen();
        gap_max = 0;
        stall_max = 0;
        hold_off_req = HoldOffCycles;
        for (i = 0; i < 24; i++)
        begin
            req_op = 1'($urandom_range(0, 1));
            send_request(req_op, pick_value(req_op));
        end
        wait_all_bytes_seen();
    endtask

    task automatic test_random_requests(input int count);
        logic req_op;
        int   i;
        for (i = 0; i < count; i++)
        begin
            // stretches of no idling alternate with busy ones on each side
            if (i % 40 == 0)
            begin
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            end
            req_op = 1'($urandom_range(0, 1));
            send_request(req_op, pick_value(req_op));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= RegMode;
        cfg_data <= '0;
        push <= 1'b0;
        op <= OpNumber;
        value <= '0;
        mode_shadow = ModeReset;
        control_shadow = ControlReset;
        setup_sent = 1'b0;
        error_count = 0;
        cycle_count = 0;
        gap_max = 6;
        stall_max = 6;
        hold_off_req = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_setup();
        test_number_extremes();
        test_error_codes();
        test_late_register_write();
        test_full_queue_stall();
        gap_max = 6;
        stall_max = 6;
        test_random_requests(268);

        wait_all_bytes_seen();
        repeat (DrainCycles) @(posedge clk);
        if (wire_bytes_due.size() != 0)
            report_mismatch("bytes never seen", wire_bytes_due.size(), 0);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hdl/tdls_pkg.sv
hdl/tdls_front.sv
hdl/tdls_queue.sv
hdl/tdls_back.sv
hdl/two_digit_led_frame_sequencer_top.sv
tb/sv/tb_two_digit_led_frame_sequencer_top.sv
